// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition leads to a consequence in the next cycle, outside reset
`define LGS_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("lgs assertion failed");

// Check that a condition leads to a consequence in the next cycle, reset included
`define LGS_ASSERT_NEXT_ALWAYS(lbl, clk, cond, cons) \
  lbl: assert property (@(posedge clk) (cond) |=> (cons)) \
    else $error("lgs assertion failed");

`endif

// File: rtl/core/lgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lgs_pkg;

  // Default sizes
  localparam int MAX_TOPICS_DEF = 64;
  localparam int MAX_VOCAB_DEF  = 4096;
  localparam int MAX_DOCS_DEF   = 1024;

  // Store and datapath widths
  localparam int DT_W   = 16;
  localparam int TW_W   = 20;
  localparam int TT_W   = 24;
  localparam int SC_W   = 32;
  localparam int FRAC_W = 12;
  localparam int A_W    = 29;
  localparam int B_W    = 33;
  localparam int NUM_W  = 62;
  localparam int DEN_W  = 37;
  localparam int VB_W   = 29;
  localparam int RND_W  = 16;

  // Register reset values
  localparam logic [15:0] ALPHA_RST = 16'd4096;
  localparam logic [15:0] BETA_RST  = 16'd410;
  localparam logic [6:0]  TOPICS_RST = 7'd64;
  localparam logic [12:0] VOCAB_RST = 13'd4096;

  typedef enum logic [1:0] {
    REG_ALPHA  = 2'd0,
    REG_BETA   = 2'd1,
    REG_TOPICS = 2'd2,
    REG_VOCAB  = 2'd3
  } lgs_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WRAP,
    ST_REM_RD,
    ST_REM_WR,
    ST_SC_RD,
    ST_SC_LD,
    ST_SC_MUL,
    ST_SC_GO,
    ST_SC_DIV,
    ST_TGT,
    ST_WK_RD,
    ST_WK_CHK,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_DONE
  } lgs_state_t;

  // Count store access request
  typedef struct packed {
    logic rd;
    logic wr;
  } lgs_mem_cmd_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } lgs_div_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/lgs_count_store.sv
`timescale 1ns / 1ps
`default_nettype none
module lgs_count_store #(
  parameter int MAX_TOPICS = lgs_pkg::MAX_TOPICS_DEF,
  parameter int MAX_VOCAB  = lgs_pkg::MAX_VOCAB_DEF,
  parameter int MAX_DOCS   = lgs_pkg::MAX_DOCS_DEF,
  localparam int DT_DEPTH  = MAX_DOCS * MAX_TOPICS,
  localparam int TW_DEPTH  = MAX_TOPICS * MAX_VOCAB,
  localparam int DTAW      = (DT_DEPTH > 1) ? $clog2(DT_DEPTH) : 1,
  localparam int TWAW      = $clog2(TW_DEPTH),
  localparam int KW        = $clog2(MAX_TOPICS)
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  lgs_pkg::lgs_mem_cmd_t      cmd,
  input  wire [DTAW-1:0]             dt_addr,
  input  wire [TWAW-1:0]             tw_addr,
  input  wire [KW-1:0]               tt_addr,
  input  wire [lgs_pkg::DT_W-1:0]    dt_wdata,
  input  wire [lgs_pkg::TW_W-1:0]    tw_wdata,
  input  wire [lgs_pkg::TT_W-1:0]    tt_wdata,
  output logic [lgs_pkg::DT_W-1:0]   dt_rdata,
  output logic [lgs_pkg::TW_W-1:0]   tw_rdata,
  output logic [lgs_pkg::TT_W-1:0]   tt_rdata,
  output logic                       clear_done
);

  localparam int CLR_DEPTH = (DT_DEPTH > TW_DEPTH) ? DT_DEPTH : TW_DEPTH;
  localparam int CLRW      = $clog2(CLR_DEPTH);

  logic [lgs_pkg::DT_W-1:0] dt_mem [DT_DEPTH];
  logic [lgs_pkg::TW_W-1:0] tw_mem [TW_DEPTH];
  logic [lgs_pkg::TT_W-1:0] tt_mem [MAX_TOPICS];

  logic            clearing_r, clearing_nxt;
  logic [CLRW-1:0] clr_r, clr_nxt;
  logic            dt_we, tw_we, tt_we;
  logic [DTAW-1:0] dt_wa;
  logic [TWAW-1:0] tw_wa;
  logic [KW-1:0]   tt_wa;

  // Advance the clearing sweep after reset
  always_comb begin
    clearing_nxt = clearing_r;
    clr_nxt      = clr_r;
    if (clearing_r) begin
      clr_nxt = clr_r + CLRW'(1);
      if (int'(clr_r) == CLR_DEPTH - 1) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_r      <= clr_nxt;
    end
  end

  assign clear_done = !clearing_r;

  // Select write port between sweep and sequencer
  always_comb begin
    if (clearing_r) begin
      dt_we = int'(clr_r) < DT_DEPTH;
      tw_we = int'(clr_r) < TW_DEPTH;
      tt_we = int'(clr_r) < MAX_TOPICS;
      dt_wa = clr_r[DTAW-1:0];
      tw_wa = clr_r[TWAW-1:0];
      tt_wa = clr_r[KW-1:0];
    end else begin
      dt_we = cmd.wr;
      tw_we = cmd.wr;
      tt_we = cmd.wr;
      dt_wa = dt_addr;
      tw_wa = tw_addr;
      tt_wa = tt_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (dt_we) begin
      dt_mem[dt_wa] <= clearing_r ? '0 : dt_wdata;
    end
    if (cmd.rd) begin
      dt_rdata <= dt_mem[dt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tw_we) begin
      tw_mem[tw_wa] <= clearing_r ? '0 : tw_wdata;
    end
    if (cmd.rd) begin
      tw_rdata <= tw_mem[tw_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tt_we) begin
      tt_mem[tt_wa] <= clearing_r ? '0 : tt_wdata;
    end
    if (cmd.rd) begin
      tt_rdata <= tt_mem[tt_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/lgs_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module lgs_divider (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [lgs_pkg::NUM_W-1:0]   num,
  input  wire [lgs_pkg::DEN_W-1:0]   den,
  output lgs_pkg::lgs_div_stat_t     stat,
  output logic [lgs_pkg::SC_W-1:0]   quot
);

  // Quotient of num*16/den, one bit a cycle, saturating at all ones
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [4:0]                  cnt_r, cnt_nxt;
  logic [lgs_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [lgs_pkg::DEN_W-1:0]   rem_r, rem_nxt;
  logic [lgs_pkg::SC_W-1:0]    low_r, low_nxt;
  logic [lgs_pkg::DEN_W:0]     rem2;
  logic                        ge;
  logic                        sat;

  assign sat  = (den == '0) ||
                ((lgs_pkg::NUM_W + 3)'(num) >= {den, 28'b0});
  assign rem2 = {rem_r, low_r[lgs_pkg::SC_W-1]};
  assign ge   = rem2 >= (lgs_pkg::DEN_W + 1)'(den_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    if (start) begin
      den_nxt = den;
      cnt_nxt = '0;
      if (sat) begin
        low_nxt  = '1;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = lgs_pkg::DEN_W'(num[lgs_pkg::NUM_W-1:28]);
        low_nxt  = {num[27:0], 4'b0};
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // Shift in one dividend bit, subtract where it fits
      rem_nxt = ge ? lgs_pkg::DEN_W'(rem2 - (lgs_pkg::DEN_W + 1)'(den_r))
                   : lgs_pkg::DEN_W'(rem2);
      low_nxt = {low_r[lgs_pkg::SC_W-2:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = low_r;

endmodule
`default_nettype wire

// File: rtl/core/lda_gibbs_token_sampler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake          | Payload
// in       | in_valid/in_ready  | in_operation, in_doc_index, in_word_index,
//          |                    | in_old_topic, in_random_fraction
// out      | out_valid/out_ready| out_new_topic, out_count_underflow
// config   | APB psel/penable   | paddr, pwdata, prdata (4 registers)
//
// A resample item scores each of the n topics in use, then walks the topics up to and
// including the pick; an add item goes straight to the count update.
// Each topic's score takes a divider pass, which a saturated score skips.
// After reset the count stores are swept to zero over MAX_TOPICS*max(MAX_DOCS, MAX_VOCAB)
// addresses (262144 by default), and no item is taken meanwhile.
// The result register lets the next item enter while a result waits for out_ready.
module lda_gibbs_token_sampler_top #(
  parameter int MAX_TOPICS = lgs_pkg::MAX_TOPICS_DEF,
  parameter int MAX_VOCAB  = lgs_pkg::MAX_VOCAB_DEF,
  parameter int MAX_DOCS   = lgs_pkg::MAX_DOCS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_operation,
  input  wire  [9:0]  in_doc_index,
  input  wire  [11:0] in_word_index,
  input  wire  [5:0]  in_old_topic,
  input  wire  [15:0] in_random_fraction,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [5:0]  out_new_topic,
  output logic        out_count_underflow,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int KW   = $clog2(MAX_TOPICS);
  localparam int NW   = $clog2(MAX_TOPICS + 1);
  localparam int DW   = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
  localparam int VW   = $clog2(MAX_VOCAB);
  localparam int DTAW = (MAX_DOCS * MAX_TOPICS > 1) ? $clog2(MAX_DOCS * MAX_TOPICS) : 1;
  localparam int TWAW = $clog2(MAX_TOPICS * MAX_VOCAB);
  localparam int SUMW = lgs_pkg::SC_W + KW;
  localparam int PRW  = SUMW + lgs_pkg::RND_W;

  // Configuration registers
  logic [15:0] alpha_r, beta_r;
  logic [6:0]  topics_r;
  logic [12:0] vocab_r;
  lgs_pkg::lgs_reg_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = lgs_pkg::lgs_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= lgs_pkg::ALPHA_RST;
      beta_r   <= lgs_pkg::BETA_RST;
      topics_r <= lgs_pkg::TOPICS_RST;
      vocab_r  <= lgs_pkg::VOCAB_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        lgs_pkg::REG_ALPHA:  alpha_r  <= pwdata[15:0];
        lgs_pkg::REG_BETA:   beta_r   <= pwdata[15:0];
        lgs_pkg::REG_TOPICS: topics_r <= pwdata[6:0];
        lgs_pkg::REG_VOCAB:  vocab_r  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lgs_pkg::REG_ALPHA:  prdata = 32'(alpha_r);
      lgs_pkg::REG_BETA:   prdata = 32'(beta_r);
      lgs_pkg::REG_TOPICS: prdata = 32'(topics_r);
      lgs_pkg::REG_VOCAB:  prdata = 32'(vocab_r);
      default:             prdata = '0;
    endcase
  end

  // Sequencer and item registers
  lgs_pkg::lgs_state_t state_r, state_nxt;
  logic                op_r;
  logic [9:0]          d_r;
  logic [11:0]         w_r;
  logic [KW-1:0]       t_r;
  logic [15:0]         rnd_r;
  logic [NW-1:0]       n_r;
  logic [NW-1:0]       k_r;
  logic [KW-1:0]       pick_r;
  logic                under_r;
  logic [lgs_pkg::VB_W-1:0]  vb_r;
  logic [lgs_pkg::A_W-1:0]   a_r;
  logic [lgs_pkg::B_W-1:0]   b_r;
  logic [lgs_pkg::DEN_W-1:0] den_r;
  logic [lgs_pkg::NUM_W-1:0] num_r;
  logic [SUMW-1:0]     sum_r, tgt_r, cum_r;
  logic [SUMW-1:0]     cum_nxt;
  logic [PRW-1:0]      prod;
  logic                d_big, w_big, last_k, hit;
  logic [lgs_pkg::SC_W-1:0] sc_mem [MAX_TOPICS];
  logic [lgs_pkg::SC_W-1:0] sc_rdata_r;
  logic                out_valid_r;
  logic [5:0]          out_topic_r;
  logic                out_under_r;

  // Store and divider hookup
  lgs_pkg::lgs_mem_cmd_t    mem_cmd;
  lgs_pkg::lgs_div_stat_t   div_stat;
  logic                     div_start;
  logic [lgs_pkg::SC_W-1:0] div_q;
  logic [KW-1:0]            topic_sel;
  logic [DTAW-1:0]          dt_addr;
  logic [TWAW-1:0]          tw_addr;
  logic [lgs_pkg::DT_W-1:0] dt_rdata, dt_wdata;
  logic [lgs_pkg::TW_W-1:0] tw_rdata, tw_wdata;
  logic [lgs_pkg::TT_W-1:0] tt_rdata, tt_wdata;
  logic                     clear_done;
  logic [DW-1:0]            d_idx;
  logic [VW-1:0]            w_idx;
  logic [KW-1:0]            t_in;

  assign d_big   = int'(d_r) >= MAX_DOCS;
  assign w_big   = int'(w_r) >= MAX_VOCAB;
  assign last_k  = k_r == (n_r - NW'(1));
  assign cum_nxt = cum_r + SUMW'(sc_rdata_r);
  assign hit     = cum_nxt >= tgt_r;
  assign prod    = PRW'(rnd_r) * PRW'(sum_r);
  assign d_idx   = DW'(d_r);
  assign w_idx   = VW'(w_r);
  assign t_in    = (int'(in_old_topic) >= MAX_TOPICS) ? KW'(MAX_TOPICS - 1)
                                                      : KW'(in_old_topic);
  assign dt_addr = DTAW'(int'(d_idx) * MAX_TOPICS + int'(topic_sel));
  assign tw_addr = TWAW'(int'(topic_sel) * MAX_VOCAB + int'(w_idx));

  lgs_count_store #(
    .MAX_TOPICS (MAX_TOPICS),
    .MAX_VOCAB  (MAX_VOCAB),
    .MAX_DOCS   (MAX_DOCS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (mem_cmd),
    .dt_addr    (dt_addr),
    .tw_addr    (tw_addr),
    .tt_addr    (topic_sel),
    .dt_wdata   (dt_wdata),
    .tw_wdata   (tw_wdata),
    .tt_wdata   (tt_wdata),
    .dt_rdata   (dt_rdata),
    .tw_rdata   (tw_rdata),
    .tt_rdata   (tt_rdata),
    .clear_done (clear_done)
  );

  lgs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .stat  (div_stat),
    .quot  (div_q)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lgs_pkg::ST_IDLE:   if (in_valid && in_ready) state_nxt = lgs_pkg::ST_WRAP;
      lgs_pkg::ST_WRAP: begin
        if (!d_big && !w_big) begin
          state_nxt = op_r ? lgs_pkg::ST_REM_RD : lgs_pkg::ST_ADD_RD;
        end
      end
      lgs_pkg::ST_REM_RD: state_nxt = lgs_pkg::ST_REM_WR;
      lgs_pkg::ST_REM_WR: state_nxt = lgs_pkg::ST_SC_RD;
      lgs_pkg::ST_SC_RD:  state_nxt = lgs_pkg::ST_SC_LD;
      lgs_pkg::ST_SC_LD:  state_nxt = lgs_pkg::ST_SC_MUL;
      lgs_pkg::ST_SC_MUL: state_nxt = lgs_pkg::ST_SC_GO;
      lgs_pkg::ST_SC_GO:  state_nxt = lgs_pkg::ST_SC_DIV;
      lgs_pkg::ST_SC_DIV: begin
        if (div_stat.done) begin
          state_nxt = last_k ? lgs_pkg::ST_TGT : lgs_pkg::ST_SC_RD;
        end
      end
      lgs_pkg::ST_TGT:    state_nxt = lgs_pkg::ST_WK_RD;
      lgs_pkg::ST_WK_RD:  state_nxt = lgs_pkg::ST_WK_CHK;
      lgs_pkg::ST_WK_CHK: state_nxt = (hit || last_k) ? lgs_pkg::ST_ADD_RD
                                                      : lgs_pkg::ST_WK_RD;
      lgs_pkg::ST_ADD_RD: state_nxt = lgs_pkg::ST_ADD_WR;
      lgs_pkg::ST_ADD_WR: state_nxt = lgs_pkg::ST_DONE;
      lgs_pkg::ST_DONE:   if (!out_valid_r || out_ready) state_nxt = lgs_pkg::ST_IDLE;
      default:            state_nxt = lgs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    mem_cmd   = '0;
    div_start = 1'b0;
    topic_sel = t_r;
    dt_wdata  = dt_rdata;
    tw_wdata  = tw_rdata;
    tt_wdata  = tt_rdata;
    case (state_r)
      lgs_pkg::ST_REM_RD: mem_cmd.rd = 1'b1;
      lgs_pkg::ST_REM_WR: begin
        mem_cmd.wr = 1'b1;
        dt_wdata = (dt_rdata == '0) ? '0 : dt_rdata - lgs_pkg::DT_W'(1);
        tw_wdata = (tw_rdata == '0) ? '0 : tw_rdata - lgs_pkg::TW_W'(1);
        tt_wdata = (tt_rdata == '0) ? '0 : tt_rdata - lgs_pkg::TT_W'(1);
      end
      lgs_pkg::ST_SC_RD: begin
        mem_cmd.rd = 1'b1;
        topic_sel  = k_r[KW-1:0];
      end
      lgs_pkg::ST_SC_GO:  div_start = 1'b1;
      lgs_pkg::ST_ADD_RD: begin
        mem_cmd.rd = 1'b1;
        topic_sel  = op_r ? pick_r : t_r;
      end
      lgs_pkg::ST_ADD_WR: begin
        mem_cmd.wr = 1'b1;
        topic_sel  = op_r ? pick_r : t_r;
        dt_wdata = (&dt_rdata) ? dt_rdata : dt_rdata + lgs_pkg::DT_W'(1);
        tw_wdata = (&tw_rdata) ? tw_rdata : tw_rdata + lgs_pkg::TW_W'(1);
        tt_wdata = (&tt_rdata) ? tt_rdata : tt_rdata + lgs_pkg::TT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lgs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      lgs_pkg::ST_IDLE: begin
        op_r  <= in_operation;
        d_r   <= in_doc_index;
        w_r   <= in_word_index;
        t_r   <= t_in;
        rnd_r <= in_random_fraction;
        if (topics_r == '0) begin
          n_r <= NW'(1);
        end else if (int'(topics_r) > MAX_TOPICS) begin
          n_r <= NW'(MAX_TOPICS);
        end else begin
          n_r <= NW'(topics_r);
        end
      end
      lgs_pkg::ST_WRAP: begin
        // Wrap indexes into range, one subtraction a cycle
        if (d_big) d_r <= d_r - 10'(MAX_DOCS);
        if (w_big) w_r <= w_r - 12'(MAX_VOCAB);
        vb_r    <= lgs_pkg::VB_W'(vocab_r) * lgs_pkg::VB_W'(beta_r);
        under_r <= 1'b0;
        k_r     <= '0;
        sum_r   <= '0;
      end
      lgs_pkg::ST_REM_WR: begin
        under_r <= (dt_rdata == '0) || (tw_rdata == '0) || (tt_rdata == '0);
      end
      lgs_pkg::ST_SC_LD: begin
        a_r   <= lgs_pkg::A_W'({dt_rdata, 12'b0}) + lgs_pkg::A_W'(alpha_r);
        b_r   <= lgs_pkg::B_W'({tw_rdata, 12'b0}) + lgs_pkg::B_W'(beta_r);
        den_r <= lgs_pkg::DEN_W'({tt_rdata, 12'b0}) + lgs_pkg::DEN_W'(vb_r);
      end
      lgs_pkg::ST_SC_MUL: begin
        num_r <= lgs_pkg::NUM_W'(a_r) * lgs_pkg::NUM_W'(b_r);
      end
      lgs_pkg::ST_SC_DIV: begin
        if (div_stat.done) begin
          sum_r <= sum_r + SUMW'(div_q);
          k_r   <= last_k ? '0 : k_r + NW'(1);
        end
      end
      lgs_pkg::ST_TGT: begin
        tgt_r <= prod[PRW-1:lgs_pkg::RND_W];
        cum_r <= '0;
      end
      lgs_pkg::ST_WK_CHK: begin
        // Stop at the first running sum that reaches the target, or at the last topic in use
        cum_r <= cum_nxt;
        if (hit || last_k) begin
          pick_r <= k_r[KW-1:0];
        end else begin
          k_r <= k_r + NW'(1);
        end
      end
      default: ;
    endcase
  end

  // Score memory
  always_ff @(posedge clk) begin
    if (state_r == lgs_pkg::ST_SC_DIV && div_stat.done) begin
      sc_mem[k_r[KW-1:0]] <= div_q;
    end
    if (state_r == lgs_pkg::ST_WK_RD) begin
      sc_rdata_r <= sc_mem[k_r[KW-1:0]];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == lgs_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lgs_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_topic_r <= 6'(op_r ? pick_r : t_r);
      out_under_r <= op_r && under_r;
    end
  end

  assign in_ready            = (state_r == lgs_pkg::ST_IDLE) && clear_done;
  assign out_valid           = out_valid_r;
  assign out_new_topic       = out_topic_r;
  assign out_count_underflow = out_under_r;

endmodule
`default_nettype wire

// File: rtl/core/lgs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lgs_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [5:0] out_new_topic,
  input wire       out_count_underflow
);

  // An accepted item blocks the input until its work is done
  `LGS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // No result straight after reset
  `LGS_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid)

  // A waiting result holds
  `LGS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_new_topic) && $stable(out_count_underflow))

endmodule

bind lda_gibbs_token_sampler_top lgs_checker u_lgs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_new_topic       (out_new_topic),
  .out_count_underflow (out_count_underflow)
);
`default_nettype wire
